/* sv/lcdsw_pkg.sv */
package lcdsw_pkg;

	localparam int DISPLAY_WORDS_DEF = 32;

	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 4;
	localparam int CODE_W  = 8;
	localparam int CMD_W   = 3;
	localparam int TICK_W  = 8;
	localparam int FRAME_W = 13;
	localparam int BITS_W  = 4;

	localparam logic [CMD_W-1:0] CMD_SEND     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RAM      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FULL_ON  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FULL_OFF = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BL_ON    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_BL_OFF   = 3'd5;

	localparam logic [2:0] CMD_PREFIX = 3'b100;
	localparam logic [2:0] RAM_PREFIX = 3'b101;

	localparam logic [BITS_W-1:0] CMD_FRAME_BITS = 4'd12;
	localparam logic [BITS_W-1:0] RAM_FRAME_BITS = 4'd13;

	localparam logic [DATA_W-1:0] FULL_ON_DATA = 4'hF;
	localparam logic [DATA_W-1:0] NOTCH_DATA   = 4'hE;
	localparam logic [ADDR_W-1:0] NOTCH_ADDR   = 6'd7;
	localparam logic [ADDR_W-1:0] SKIP_FROM    = 6'd17;
	localparam logic [ADDR_W-1:0] SKIP_TO      = 6'd30;

	localparam logic [TICK_W-1:0] LOW_TICKS_RST  = 8'd9;
	localparam logic [TICK_W-1:0] HIGH_TICKS_RST = 8'd4;

	localparam logic REG_LOW_TICKS  = 1'b0;
	localparam logic REG_HIGH_TICKS = 1'b1;

	typedef struct packed {
		logic              request_valid;
		logic [CMD_W-1:0]  command;
		logic [CODE_W-1:0] command_code;
		logic [ADDR_W-1:0] ram_address;
		logic [DATA_W-1:0] ram_data;
	} in_t;

	typedef struct packed {
		logic chip_select_n;
		logic write_strobe_n;
		logic data_line;
		logic backlight;
		logic busy_res;
		logic request_dropped;
	} out_t;

	function automatic logic [TICK_W-1:0] dur(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

	// 100, code MSB first, trailing 0, one pad bit never sent
	function automatic logic [FRAME_W-1:0] cmd_frame(input logic [CODE_W-1:0] code);
		return {CMD_PREFIX, code, 2'b00};
	endfunction

	// 101, address MSB first, data LSB first
	function automatic logic [FRAME_W-1:0] ram_frame(input logic [ADDR_W-1:0] addr,
		input logic [DATA_W-1:0] data);
		return {RAM_PREFIX, addr, data[0], data[1], data[2], data[3]};
	endfunction

endpackage

/* sv/lcd_controller_serial_writer_unit.sv */
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | in_data (lcdsw_pkg::in_t)
// out     | out | out_valid/out_stall | out_data (lcdsw_pkg::out_t)
// cfg     | in  | cfg_we              | cfg_index, cfg_wdata
//
// One transaction per cycle while in_stall is low; each input transaction is one
// pin tick and yields one result in the next cycle, through the result register.
// arst_n clears the sequencer (idle, backlight off) and the strobe timing registers
// (low 9, high 4 ticks).
// in_stall is high only while a result is held and out_stall is high.
module lcd_controller_serial_writer_unit #(
	parameter int DISPLAY_WORDS = lcdsw_pkg::DISPLAY_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lcdsw_pkg::in_t                in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lcdsw_pkg::out_t               out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [lcdsw_pkg::TICK_W-1:0]  cfg_wdata
);

	logic [lcdsw_pkg::TICK_W-1:0] low_ticks_q;
	logic [lcdsw_pkg::TICK_W-1:0] high_ticks_q;
	logic                         accept;
	lcdsw_pkg::out_t              result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_ticks_q  <= lcdsw_pkg::LOW_TICKS_RST;
			high_ticks_q <= lcdsw_pkg::HIGH_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcdsw_pkg::REG_LOW_TICKS:  low_ticks_q  <= cfg_wdata;
				lcdsw_pkg::REG_HIGH_TICKS: high_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall = out_valid & out_stall;
	assign accept   = in_valid & ~in_stall;

	lcdsw_core #(
		.DISPLAY_WORDS(DISPLAY_WORDS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.item       (in_data),
		.low_ticks  (low_ticks_q),
		.high_ticks (high_ticks_q),
		.result     (result)
	);

	lcdsw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.result    (result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

/* sv/lcdsw_core.sv */
module lcdsw_core #(
	parameter int DISPLAY_WORDS = lcdsw_pkg::DISPLAY_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  lcdsw_pkg::in_t                      item,
	input  logic [lcdsw_pkg::TICK_W-1:0]        low_ticks,
	input  logic [lcdsw_pkg::TICK_W-1:0]        high_ticks,
	output lcdsw_pkg::out_t                     result
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;
	localparam logic [1:0] PH_END  = 2'd3;

	localparam logic [1:0] SEQ_NONE = 2'd0;
	localparam logic [1:0] SEQ_ON   = 2'd1;
	localparam logic [1:0] SEQ_OFF  = 2'd2;

	localparam int AW = lcdsw_pkg::ADDR_W;

	logic [1:0]                       phase_q, phase_d;
	logic [lcdsw_pkg::FRAME_W-1:0]    shift_q, shift_d;
	logic [lcdsw_pkg::BITS_W-1:0]     bits_q, bits_d, bits_dec;
	logic [lcdsw_pkg::TICK_W-1:0]     tick_q, tick_d, tick_dec;
	logic [1:0]                       kind_q, kind_d;
	logic [AW-1:0]                    addr_q, addr_d;
	logic                             bl_q, bl_d;
	logic [AW:0]                      next_addr;
	logic [lcdsw_pkg::DATA_W-1:0]     seq_data;
	logic                             framing;

	always_comb begin
		phase_d   = phase_q;
		shift_d   = shift_q;
		bits_d    = bits_q;
		tick_d    = tick_q;
		kind_d    = kind_q;
		addr_d    = addr_q;
		bl_d      = bl_q;
		tick_dec  = tick_q - lcdsw_pkg::TICK_W'(tick_q != '0);
		bits_dec  = bits_q - lcdsw_pkg::BITS_W'(bits_q != '0);
		next_addr = {1'b0, addr_q} + (AW+1)'(1);
		if (kind_q == SEQ_ON && addr_q == lcdsw_pkg::SKIP_FROM)
			next_addr = {1'b0, lcdsw_pkg::SKIP_TO};
		seq_data = '0;
		if (kind_q == SEQ_ON)
			seq_data = (next_addr[AW-1:0] == lcdsw_pkg::NOTCH_ADDR) ?
				lcdsw_pkg::NOTCH_DATA : lcdsw_pkg::FULL_ON_DATA;

		unique case (phase_q)
			PH_IDLE: begin
				if (item.request_valid) begin
					unique case (item.command)
						lcdsw_pkg::CMD_SEND: begin
							shift_d = lcdsw_pkg::cmd_frame(item.command_code);
							bits_d  = lcdsw_pkg::CMD_FRAME_BITS;
							phase_d = PH_LOW;
							tick_d  = lcdsw_pkg::dur(low_ticks);
						end
						lcdsw_pkg::CMD_RAM: begin
							shift_d = lcdsw_pkg::ram_frame(item.ram_address, item.ram_data);
							bits_d  = lcdsw_pkg::RAM_FRAME_BITS;
							phase_d = PH_LOW;
							tick_d  = lcdsw_pkg::dur(low_ticks);
						end
						lcdsw_pkg::CMD_FULL_ON, lcdsw_pkg::CMD_FULL_OFF: begin
							kind_d  = (item.command == lcdsw_pkg::CMD_FULL_ON) ? SEQ_ON : SEQ_OFF;
							addr_d  = '0;
							shift_d = lcdsw_pkg::ram_frame('0,
								(item.command == lcdsw_pkg::CMD_FULL_ON) ?
								lcdsw_pkg::FULL_ON_DATA : '0);
							bits_d  = lcdsw_pkg::RAM_FRAME_BITS;
							phase_d = PH_LOW;
							tick_d  = lcdsw_pkg::dur(low_ticks);
						end
						lcdsw_pkg::CMD_BL_ON:  bl_d = 1'b1;
						lcdsw_pkg::CMD_BL_OFF: bl_d = 1'b0;
						default: ;
					endcase
				end
			end
			PH_LOW: begin
				tick_d = tick_dec;
				if (tick_dec == '0) begin
					phase_d = PH_HIGH;
					tick_d  = lcdsw_pkg::dur(high_ticks);
				end
			end
			PH_HIGH: begin
				tick_d = tick_dec;
				if (tick_dec == '0) begin
					shift_d = {shift_q[lcdsw_pkg::FRAME_W-2:0], 1'b0};
					bits_d  = bits_dec;
					if (bits_dec == '0) begin
						phase_d = PH_END;
					end else begin
						phase_d = PH_LOW;
						tick_d  = lcdsw_pkg::dur(low_ticks);
					end
				end
			end
			PH_END: begin
				if (kind_q == SEQ_NONE) begin
					phase_d = PH_IDLE;
				end else if (next_addr >= (AW+1)'(DISPLAY_WORDS)) begin
					kind_d  = SEQ_NONE;
					addr_d  = '0;
					phase_d = PH_IDLE;
				end else begin
					addr_d  = next_addr[AW-1:0];
					shift_d = lcdsw_pkg::ram_frame(next_addr[AW-1:0], seq_data);
					bits_d  = lcdsw_pkg::RAM_FRAME_BITS;
					phase_d = PH_LOW;
					tick_d  = lcdsw_pkg::dur(low_ticks);
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	assign framing = (phase_d == PH_LOW) || (phase_d == PH_HIGH);

	always_comb begin
		result.chip_select_n   = ~framing;
		result.write_strobe_n  = (phase_d != PH_LOW);
		result.data_line       = framing & shift_d[lcdsw_pkg::FRAME_W-1];
		result.backlight       = bl_d;
		result.busy_res        = (phase_d != PH_IDLE);
		result.request_dropped = item.request_valid && (phase_q != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			shift_q <= '0;
			bits_q  <= '0;
			tick_q  <= '0;
			kind_q  <= SEQ_NONE;
			addr_q  <= '0;
			bl_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			tick_q  <= tick_d;
			kind_q  <= kind_d;
			addr_q  <= addr_d;
			bl_q    <= bl_d;
		end
	end

`ifndef SYNTHESIS
	a_frame_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LOW || phase_q == PH_HIGH) |-> (bits_q != '0))
		else $error("frame phase with no bits left");

	a_frame_has_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LOW || phase_q == PH_HIGH) |-> (tick_q != '0))
		else $error("strobe phase with zero tick count");

	a_seq_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q != SEQ_NONE) |-> (phase_q != PH_IDLE))
		else $error("sequence pending while idle");

	a_seq_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q != SEQ_NONE) |-> ({1'b0, addr_q} < (AW+1)'(DISPLAY_WORDS)))
		else $error("sequence address past display size");
`endif

endmodule

/* sv/lcdsw_out_reg.sv */
module lcdsw_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  lcdsw_pkg::out_t result,
	input  logic            out_stall,
	output logic            out_valid,
	output lcdsw_pkg::out_t out_data
);

	logic            valid_q;
	lcdsw_pkg::out_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= result;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
